// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked at every edge outside reset.
`define SHA1DE_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication.
`define SHA1DE_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SHA1DE_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sha1de_pkg.sv -----
package sha1de_pkg;

   localparam int WORD_W  = 32;
   localparam int NB_W    = 3;
   localparam int IDX_W   = 3;
   localparam int POS_W   = 4;
   localparam int CNT_W   = 61;
   localparam int ROUND_W = 7;

   localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
   localparam logic [IDX_W-1:0]   LAST_IDX   = 3'd4;
   localparam logic [NB_W-1:0]    FULL_BYTES = 3'd4;

   localparam logic [31:0] K_0 = 32'h5A827999;
   localparam logic [31:0] K_1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_3 = 32'hCA62C1D6;

   localparam logic [31:0] PAD_WORD = 32'h80000000;

   typedef logic [WORD_W-1:0] word_type;

   function automatic word_type init_chain(input logic [IDX_W-1:0] idx);
      word_type v;
      unique case (idx)
         3'd0: v = 32'h67452301;
         3'd1: v = 32'hefcdab89;
         3'd2: v = 32'h98badcfe;
         3'd3: v = 32'h10325476;
         default: v = 32'hc3d2e1f0;
      endcase
      return v;
   endfunction

   function automatic word_type round_k(input logic [ROUND_W-1:0] t);
      word_type k;
      priority if (t < 7'd20) k = K_0;
      else if (t < 7'd40)     k = K_1;
      else if (t < 7'd60)     k = K_2;
      else                    k = K_3;
      return k;
   endfunction

   function automatic word_type round_f(input logic [ROUND_W-1:0] t,
                                        input word_type b,
                                        input word_type c,
                                        input word_type d);
      word_type f;
      priority if (t < 7'd20)            f = d ^ (b & (c ^ d));
      else if (t >= 7'd40 && t < 7'd60)  f = (b & c) | (d & (b | c));
      else                               f = b ^ c ^ d;
      return f;
   endfunction

endpackage

// ----- rtl/sha1de_req_if.sv -----
interface sha1de_req_if;
   logic                         valid;
   logic                         ready;
   logic [sha1de_pkg::WORD_W-1:0] data_word;
   logic [sha1de_pkg::NB_W-1:0]   bytes_valid;
   logic                         is_last;

   modport source (output valid, data_word, bytes_valid, is_last, input ready);
   modport sink   (input valid, data_word, bytes_valid, is_last, output ready);
endinterface

// ----- rtl/sha1de_rsp_if.sv -----
interface sha1de_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sha1de_pkg::WORD_W-1:0] digest_word;
   logic [sha1de_pkg::IDX_W-1:0]  word_index;
   logic                          last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- rtl/sha1_digest_engine_core.sv -----
// SHA-1 hash engine. Message words enter big-endian on req_if, four bytes each; the word
// flagged is_last carries 0..4 bytes (codes above 4 count as 4). A plain word is taken while
// the engine is idle. Every 16th word starts a compression: a prefetch step (S_LOAD) from the
// schedule memory, 80 rounds at one round per cycle, and a fold into the chaining words
// (S_FINAL); req_if holds ready low from the 16th word until the fold is done.
// The round rate is set by the schedule memory: each round reads three schedule entries (two
// ports on one copy, one on a second copy) and, from round 16 on, writes back the expanded
// word. On the last word the engine writes the pad, zero fill and bit length one word per
// cycle, compresses once or twice, then offers the five digest words on rsp_if, index 0
// first, and restarts from the initial chaining values. No new item is taken until the fifth
// digest word has been accepted.
`include "assert_macros.svh"

module sha1_digest_engine_core (
   input  logic        clock,
   input  logic        reset,
   sha1de_req_if.sink  req_if,
   sha1de_rsp_if.source rsp_if
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAD   = 3'd1;
   localparam logic [2:0] S_LOAD  = 3'd2;
   localparam logic [2:0] S_ROUND = 3'd3;
   localparam logic [2:0] S_FINAL = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   localparam logic [2:0] PH_DATA  = 3'd0;
   localparam logic [2:0] PH_MARK  = 3'd1;
   localparam logic [2:0] PH_ZERO  = 3'd2;
   localparam logic [2:0] PH_LENLO = 3'd3;
   localparam logic [2:0] PH_DONE  = 3'd4;

   localparam logic [sha1de_pkg::POS_W-1:0] POS_LAST = 4'd15;
   localparam logic [sha1de_pkg::POS_W-1:0] POS_LEN  = 4'd14;

   logic [2:0]                          state_ff, state_in;
   logic [2:0]                          phase_ff, phase_in;
   logic [sha1de_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [sha1de_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [sha1de_pkg::ROUND_W-1:0]      round_ff, round_in;
   logic                                pad_ff, pad_in;
   logic [sha1de_pkg::IDX_W-1:0]        out_idx_ff, out_idx_in;
   logic [sha1de_pkg::NB_W-1:0]         nb_ff, nb_in;
   sha1de_pkg::word_type                last_data_ff, last_data_in;
   sha1de_pkg::word_type                h_ff [5];
   sha1de_pkg::word_type                h_in [5];
   sha1de_pkg::word_type                a_ff, b_ff, c_ff, d_ff, e_ff;
   sha1de_pkg::word_type                a_in, b_in, c_in, d_in, e_in;
   sha1de_pkg::word_type                wl_ff [3];
   sha1de_pkg::word_type                wl_in [3];

   // Two copies of the 16-word schedule, written together.
   sha1de_pkg::word_type                sched_a_mem [16];
   sha1de_pkg::word_type                sched_b_mem [16];
   sha1de_pkg::word_type                rd_w16_ff, rd_w14_ff, rd_w8_ff;
   logic [sha1de_pkg::POS_W-1:0]        rd_base;
   logic                                wr_en;
   logic [sha1de_pkg::POS_W-1:0]        wr_addr;
   sha1de_pkg::word_type                wr_data;

   logic                                req_acc, rsp_acc;
   logic [sha1de_pkg::NB_W-1:0]         nb_clamp;
   sha1de_pkg::word_type                merged, w_cur, x_cur, tmp;

   assign req_acc  = req_if.valid && req_if.ready;
   assign rsp_acc  = rsp_if.valid && rsp_if.ready;
   assign nb_clamp = (req_if.bytes_valid > sha1de_pkg::FULL_BYTES) ? sha1de_pkg::FULL_BYTES
                                                                    : req_if.bytes_valid;

   assign req_if.ready        = (state_ff == S_IDLE);
   assign rsp_if.valid        = (state_ff == S_OUT);
   assign rsp_if.digest_word  = h_ff[out_idx_ff];
   assign rsp_if.word_index   = out_idx_ff;
   assign rsp_if.last_word    = (out_idx_ff == sha1de_pkg::LAST_IDX);

   // Read addresses are round_ff + 1, as the read data are registered; round 0 is prefetched in S_LOAD.
   assign rd_base = (state_ff == S_ROUND) ? round_ff[3:0] + 4'd1 : 4'd0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sched_a_mem[wr_addr] <= wr_data;
         sched_b_mem[wr_addr] <= wr_data;
      end
      rd_w16_ff <= sched_a_mem[rd_base];
      rd_w14_ff <= sched_a_mem[rd_base + 4'd2];
      rd_w8_ff  <= sched_b_mem[rd_base + 4'd8];
   end

   // Final word with pad byte after the valid bytes; a full word passes unchanged.
   always_comb begin
      unique case (nb_ff)
         3'd0:    merged = sha1de_pkg::PAD_WORD;
         3'd1:    merged = {last_data_ff[31:24], 24'h800000};
         3'd2:    merged = {last_data_ff[31:16], 16'h8000};
         3'd3:    merged = {last_data_ff[31:8], 8'h80};
         default: merged = last_data_ff;
      endcase
   end

   assign x_cur = wl_ff[2] ^ rd_w8_ff ^ rd_w14_ff ^ rd_w16_ff;
   assign w_cur = (round_ff < 7'd16) ? rd_w16_ff : {x_cur[30:0], x_cur[31]};
   assign tmp   = {a_ff[26:0], a_ff[31:27]}
                  + sha1de_pkg::round_f(round_ff, b_ff, c_ff, d_ff)
                  + e_ff + sha1de_pkg::round_k(round_ff) + w_cur;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      round_in     = round_ff;
      pad_in       = pad_ff;
      out_idx_in   = out_idx_ff;
      nb_in        = nb_ff;
      last_data_in = last_data_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      for (int i = 0; i < 5; i++) h_in[i] = h_ff[i];
      for (int i = 0; i < 3; i++) wl_in[i] = wl_ff[i];
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = req_if.data_word;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (!req_if.is_last) begin
                  wr_en  = 1'b1;
                  pos_in = pos_ff + 4'd1;
                  cnt_in = cnt_ff + 61'd4;
                  pad_in = 1'b0;
                  if (pos_ff == POS_LAST) state_in = S_LOAD;
               end else begin
                  last_data_in = req_if.data_word;
                  nb_in        = nb_clamp;
                  cnt_in       = cnt_ff + sha1de_pkg::CNT_W'(nb_clamp);
                  pad_in       = 1'b1;
                  phase_in     = PH_DATA;
                  state_in     = S_PAD;
               end
            end
         end
         S_PAD: begin
            wr_en  = 1'b1;
            pos_in = pos_ff + 4'd1;
            unique case (phase_ff)
               PH_DATA: begin
                  wr_data  = merged;
                  phase_in = (nb_ff == sha1de_pkg::FULL_BYTES) ? PH_MARK : PH_ZERO;
               end
               PH_MARK: begin
                  wr_data  = sha1de_pkg::PAD_WORD;
                  phase_in = PH_ZERO;
               end
               PH_ZERO: begin
                  // length high word lands in slot 14
                  if (pos_ff == POS_LEN) begin
                     wr_data  = cnt_ff[60:29];
                     phase_in = PH_LENLO;
                  end else begin
                     wr_data  = '0;
                  end
               end
               PH_LENLO: begin
                  wr_data  = {cnt_ff[28:0], 3'b000};
                  phase_in = PH_DONE;
               end
               default: begin
                  wr_en  = 1'b0;
                  pos_in = pos_ff;
               end
            endcase
            if (wr_en && pos_ff == POS_LAST) state_in = S_LOAD;
         end
         S_LOAD: begin
            a_in = h_ff[0]; b_in = h_ff[1]; c_in = h_ff[2]; d_in = h_ff[3]; e_in = h_ff[4];
            round_in = '0;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            e_in = d_ff;
            d_in = c_ff;
            c_in = {b_ff[1:0], b_ff[31:2]};
            b_in = a_ff;
            a_in = tmp;
            wl_in[0] = w_cur;
            wl_in[1] = wl_ff[0];
            wl_in[2] = wl_ff[1];
            if (round_ff >= 7'd16) begin
               wr_en   = 1'b1;
               wr_addr = round_ff[3:0];
               wr_data = w_cur;
            end
            if (round_ff == sha1de_pkg::LAST_ROUND) state_in = S_FINAL;
            else round_in = round_ff + 7'd1;
         end
         S_FINAL: begin
            h_in[0] = h_ff[0] + a_ff;
            h_in[1] = h_ff[1] + b_ff;
            h_in[2] = h_ff[2] + c_ff;
            h_in[3] = h_ff[3] + d_ff;
            h_in[4] = h_ff[4] + e_ff;
            priority if (!pad_ff) begin
               state_in = S_IDLE;
            end else if (phase_ff == PH_DONE) begin
               out_idx_in = '0;
               state_in   = S_OUT;
            end else begin
               state_in = S_PAD;
            end
         end
         S_OUT: begin
            if (rsp_acc) begin
               if (out_idx_ff == sha1de_pkg::LAST_IDX) begin
                  for (int i = 0; i < 5; i++) h_in[i] = sha1de_pkg::init_chain(3'(i));
                  pos_in   = '0;
                  cnt_in   = '0;
                  pad_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         phase_ff   <= PH_DONE;
         pos_ff     <= '0;
         cnt_ff     <= '0;
         round_ff   <= '0;
         pad_ff     <= 1'b0;
         out_idx_ff <= '0;
         for (int i = 0; i < 5; i++) h_ff[i] <= sha1de_pkg::init_chain(3'(i));
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         cnt_ff     <= cnt_in;
         round_ff   <= round_in;
         pad_ff     <= pad_in;
         out_idx_ff <= out_idx_in;
         for (int i = 0; i < 5; i++) h_ff[i] <= h_in[i];
      end
   end

   always_ff @(posedge clock) begin
      nb_ff        <= nb_in;
      last_data_ff <= last_data_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
      for (int i = 0; i < 3; i++) wl_ff[i] <= wl_in[i];
   end

   `SHA1DE_CHECK(a_no_overlap, !(req_if.ready && rsp_if.valid), "input taken while digest pending")
   `SHA1DE_IMPLIES(a_round_range, state_ff == S_ROUND, round_ff <= sha1de_pkg::LAST_ROUND, "round count out of range")
   `SHA1DE_IMPLIES(a_load_aligned, state_ff == S_LOAD, pos_ff == 4'd0, "compression started on a partial block")
   `SHA1DE_IMPLIES(a_out_after_pad, rsp_if.valid, pad_ff && phase_ff == PH_DONE, "digest offered before padding finished")
   `SHA1DE_NEXT(a_restart, rsp_acc && rsp_if.last_word, state_ff == S_IDLE && pos_ff == 4'd0 && cnt_ff == '0, "engine not restarted after digest")

endmodule
